@@ rtl/core/pli_pkg.sv @@
// Shared types and constants for the positional list insert block.
package pli_pkg;

  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 2 * DATA_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DUMP   = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUMP     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [DATA_W-1:0]   code;
    logic signed [DATA_W-1:0]   price;
    logic        [POS_W-1:0]    position;
  } cmd_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   code_res;
    logic signed [DATA_W-1:0]   price_res;
    logic                       last;
  } result_t;

endpackage

@@ rtl/core/pli_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/positional_list_insert.sv @@
// Top level of the positional list insert block: ordered entry store in one RAM.
//
// A word is accepted when start is high and busy is low. An insert at the end of the list is
// written directly from the command; an insert at position p moves every later entry back
// one place through the RAM, one entry per cycle over its read and write ports, and then
// writes the new entry at p. A rejected insert and a dump of an empty list answer with a
// single result word. A dump reads one entry per cycle. Each result word is shown on result
// for exactly one cycle with result_strobe high, in the cycle after it is formed; the
// receiver cannot stall, and the final word of each command carries last.
module positional_list_insert #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pli_pkg::cmd_t    cmd,
  output logic             result_strobe,
  output pli_pkg::result_t result
);

  import pli_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PLACE = 4'b0100,
    S_DUMP  = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW-1:0]      ins_pos, ins_pos_next;
  logic [ENTRY_W-1:0] ins_entry, ins_entry_next;
  logic               result_strobe_next;
  result_t            result_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;

  logic [CW-1:0]      count_m1;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   count_ext;
  logic               dump_last;

  pli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy      = (state != S_IDLE);
  assign count_m1  = count - CW'(1);
  assign pos_ext   = CMP_W'(cmd.position);
  assign count_ext = CMP_W'(count);
  assign dump_last = (CW'(idx) == count_m1);

  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    ins_pos_next       = ins_pos;
    ins_entry_next     = ins_entry;
    result_strobe_next = 1'b0;
    result_next        = result;
    we                 = 1'b0;
    waddr              = ins_pos;
    wdata              = ins_entry;
    raddr              = idx;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.action == ACT_INSERT) begin
            if (pos_ext > count_ext) begin
              result_strobe_next = 1'b1;
              result_next        = '{ST_BADPOS, '0, '0, 1'b1};
            end else if (count == CW'(DEPTH)) begin
              result_strobe_next = 1'b1;
              result_next        = '{ST_FULL, '0, '0, 1'b1};
            end else if (pos_ext == count_ext) begin
              we                 = 1'b1;
              waddr              = cmd.position[AW-1:0];
              wdata              = {cmd.code, cmd.price};
              count_next         = count + CW'(1);
              result_strobe_next = 1'b1;
              result_next        = '{ST_INSERTED, '0, '0, 1'b1};
            end else begin
              raddr          = count_m1[AW-1:0];
              idx_next       = count_m1[AW-1:0];
              ins_pos_next   = cmd.position[AW-1:0];
              ins_entry_next = {cmd.code, cmd.price};
              state_next     = S_SHIFT;
            end
          end else begin
            if (count == '0) begin
              result_strobe_next = 1'b1;
              result_next        = '{ST_EMPTY, '0, '0, 1'b1};
            end else begin
              raddr      = '0;
              idx_next   = '0;
              state_next = S_DUMP;
            end
          end
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx + AW'(1);
        wdata = rdata;
        if (idx == ins_pos) begin
          state_next = S_PLACE;
        end else begin
          raddr    = idx - AW'(1);
          idx_next = idx - AW'(1);
        end
      end
      S_PLACE: begin
        we                 = 1'b1;
        waddr              = ins_pos;
        wdata              = ins_entry;
        count_next         = count + CW'(1);
        result_strobe_next = 1'b1;
        result_next        = '{ST_INSERTED, '0, '0, 1'b1};
        state_next         = S_IDLE;
      end
      S_DUMP: begin
        result_strobe_next = 1'b1;
        result_next        = '{ST_DUMP, rdata[ENTRY_W-1:DATA_W], rdata[DATA_W-1:0], dump_last};
        if (dump_last) begin
          state_next = S_IDLE;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      result_strobe <= result_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    ins_pos   <= ins_pos_next;
    ins_entry <= ins_entry_next;
    result    <= result_next;
  end

endmodule

@@ rtl/core/pli_checker.sv @@
// Port-level checker for the positional list insert block and its bind statement.
module pli_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_strobe,
  input pli_pkg::result_t result
);

  import pli_pkg::*;

  // Only a dump word carries entry data; every other word is final and zero.
  a_non_dump_final: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.status != ST_DUMP)) |->
      (result.last && (result.code_res == '0) && (result.price_res == '0)))
    else $error("non-dump result word is not final or carries data");

  // An accepted command either keeps the block busy or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_strobe))
    else $error("accepted command produced neither work nor a result");

  // The final word of a command leaves the block ready for the next one.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> !busy)
    else $error("block still busy when the final result word is shown");

  // A dump streams its entries in consecutive cycles until the final word.
  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |=> (result_strobe && (result.status == ST_DUMP)))
    else $error("dump stream broken before its final word");

endmodule

bind positional_list_insert pli_checker u_pli_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_strobe(result_strobe),
  .result       (result)
);
